// ===== rtl/fscf_pkg.sv =====
// shared constants, types and lookup functions of the sector chain follower
package fscf_pkg;

  localparam int SECTOR_TOTAL = 683;
  localparam int TRACK_TOTAL  = 35;

  localparam int IDX_W   = 10;
  localparam int OFS_W   = 18;
  localparam int PAY_W   = 8;
  localparam int TOTAL_W = 18;
  localparam int KIND_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 3;

  // visited bitmap is kept as rows of bits in one memory
  localparam int ROW_BITS  = 32;
  localparam int BIT_W     = $clog2(ROW_BITS);
  localparam int ROW_COUNT = (SECTOR_TOTAL + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  localparam logic [PAY_W-1:0]   DATA_PER_SECTOR = 8'd254;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = '1;
  localparam logic [KIND_W-1:0]  KIND_PROGRAM    = 3'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_TRACK     = 3'd1;
  localparam logic [STAT_W-1:0] ST_MALFORMED = 3'd2;
  localparam logic [STAT_W-1:0] ST_LOOP      = 3'd3;
  localparam logic [STAT_W-1:0] ST_TYPE      = 3'd4;
  localparam logic [STAT_W-1:0] ST_SHORT     = 3'd5;
  localparam logic [STAT_W-1:0] ST_ABORTED   = 3'd6;

  typedef struct packed {
    logic             trk_zero;
    logic             trk_err;
    logic             sec_err;
    logic [IDX_W-1:0] index;
  } locate_t;

  typedef struct packed {
    logic clear;
    logic set;
  } visit_cmd_t;

  // sectors per track in the four zones, tracks past 35 as the last zone
  function automatic logic [4:0] zone_sectors(input logic [5:0] t);
    logic [4:0] n;
    if (t <= 6'd17) begin
      n = 5'd21;
    end else if (t <= 6'd24) begin
      n = 5'd19;
    end else if (t <= 6'd30) begin
      n = 5'd18;
    end else begin
      n = 5'd17;
    end
    return n;
  endfunction

  // linear index of sector 0 of a track, valid for tracks 1 to 40
  function automatic logic [IDX_W-1:0] track_base(input logic [5:0] t);
    logic [IDX_W-1:0] b;
    if (t <= 6'd17) begin
      b = IDX_W'(10'd21 * {4'd0, t - 6'd1});
    end else if (t <= 6'd24) begin
      b = IDX_W'(10'd357 + 10'd19 * {4'd0, t - 6'd18});
    end else if (t <= 6'd30) begin
      b = IDX_W'(10'd490 + 10'd18 * {4'd0, t - 6'd25});
    end else begin
      b = IDX_W'(10'd598 + 10'd17 * {4'd0, t - 6'd31});
    end
    return b;
  endfunction

endpackage

// ===== rtl/fscf_ifs.sv =====
// valid/ready channel interfaces for sector items and result items
interface fscf_sector_if import fscf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              chain_start;
  logic [KIND_W-1:0] file_kind;
  logic [BYTE_W-1:0] track_number;
  logic [BYTE_W-1:0] sector_number;
  logic [BYTE_W-1:0] link_track;
  logic [BYTE_W-1:0] link_sector;

  modport source (output valid, chain_start, file_kind, track_number, sector_number,
                  link_track, link_sector, input ready);
  modport sink (input valid, chain_start, file_kind, track_number, sector_number,
                link_track, link_sector, output ready);
endinterface

interface fscf_result_if import fscf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OFS_W-1:0]  byte_offset;
  logic [IDX_W-1:0]  linear_index;
  logic [PAY_W-1:0]  payload_bytes;
  logic [STAT_W-1:0] status;
  logic              chain_done;

  modport source (output valid, byte_offset, linear_index, payload_bytes, status,
                  chain_done, input ready);
  modport sink (input valid, byte_offset, linear_index, payload_bytes, status,
                chain_done, output ready);
endinterface

// ===== rtl/fscf_locate.sv =====
// track and sector range checks and linear sector index
module fscf_locate import fscf_pkg::*; (
  input  logic [BYTE_W-1:0] track_number,
  input  logic [BYTE_W-1:0] sector_number,
  output locate_t           loc
);

  logic [5:0]       t6;
  logic [4:0]       zone;
  logic [IDX_W:0]   idx_sum;

  assign t6      = track_number[5:0];
  assign zone    = zone_sectors(t6);
  assign idx_sum = {1'b0, track_base(t6)} + (IDX_W + 1)'(sector_number);

  // sector and index results only matter once the track is in range
  assign loc.trk_zero = (track_number == '0);
  assign loc.trk_err  = (track_number == '0) || (track_number > BYTE_W'(TRACK_TOTAL));
  assign loc.sec_err  = (sector_number >= BYTE_W'(zone)) ||
                        (idx_sum >= (IDX_W + 1)'(SECTOR_TOTAL));
  assign loc.index    = idx_sum[IDX_W-1:0];

endmodule

// ===== rtl/fscf_visit_map.sv =====
// visited bitmap: row memory with per-row valid flops and write forwarding
module fscf_visit_map import fscf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_index,
  input  logic [IDX_W-1:0] cur_index,
  input  visit_cmd_t       cmd,
  output logic             visited
);

  logic [ROW_BITS-1:0] mem [ROW_COUNT];
  logic [ROW_BITS-1:0] rdata;
  logic [ROW_COUNT-1:0] row_valid;
  logic [ROW_COUNT-1:0] row_valid_next;
  logic                fwd_valid;
  logic [ROW_AW-1:0]   fwd_row;
  logic [ROW_BITS-1:0] fwd_word;

  logic [ROW_AW-1:0]   rd_row;
  logic [ROW_AW-1:0]   cur_row;
  logic [BIT_W-1:0]    cur_bit;
  logic [ROW_BITS-1:0] cur_word;
  logic [ROW_BITS-1:0] new_word;

  assign rd_row  = ROW_AW'(rd_index >> BIT_W);
  assign cur_row = ROW_AW'(cur_index >> BIT_W);
  assign cur_bit = cur_index[BIT_W-1:0];

  // the previous write can land on the same edge as this row's read
  always_comb begin
    if (fwd_valid && (fwd_row == cur_row)) begin
      cur_word = fwd_word;
    end else if (row_valid[cur_row]) begin
      cur_word = rdata;
    end else begin
      cur_word = '0;
    end
  end

  assign visited  = cur_word[cur_bit];
  assign new_word = (cmd.clear ? '0 : cur_word) | (ROW_BITS'(1) << cur_bit);

  always_comb begin
    row_valid_next = cmd.clear ? '0 : row_valid;
    if (cmd.set) begin
      row_valid_next[cur_row] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set) begin
      mem[cur_row] <= new_word;
    end
    if (rd_en) begin
      rdata <= mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set) begin
      fwd_row  <= cur_row;
      fwd_word <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
    end else begin
      row_valid <= row_valid_next;
      if (cmd.clear || cmd.set) begin
        fwd_valid <= cmd.set;
      end
    end
  end

  // a row is marked valid whenever it is written
  assert property (@(posedge clk) disable iff (rst)
    cmd.set |=> row_valid[$past(cur_row)])
    else $error("written row not marked valid");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.clear && !cmd.set) |=> (row_valid == '0) && !fwd_valid)
    else $error("chain start left stale bitmap rows");

  assert property (@(posedge clk) disable iff (rst)
    cmd.set |=> fwd_valid && (fwd_row == $past(cur_row)))
    else $error("forwarding register missed a write");

endmodule

// ===== rtl/file_sector_chain_follower_unit.sv =====
// top level: follows a sector chain, one sector item per transfer
// an item is registered in stage s1 and its result in the output register;
// throughput: 1 item per cycle while result.ready is high; the bitmap row
// read-modify-write is forwarded from one item to the next, so nothing else
// holds the rate; reset clears running total, abort flag, pipeline valids and
// all bitmap row valid flops; no memory clearing pass is needed
module file_sector_chain_follower_unit import fscf_pkg::*; (
  input logic           clk,
  input logic           rst,
  fscf_sector_if.sink   sector,
  fscf_result_if.source result
);

  logic                accept;
  locate_t             loc;

  logic                s1_valid;
  logic                s1_fire;
  logic                s1_start;
  logic [KIND_W-1:0]   s1_kind;
  logic [BYTE_W-1:0]   s1_link_track;
  logic [BYTE_W-1:0]   s1_link_sector;
  locate_t             s1_loc;

  logic                visited;
  visit_cmd_t          cmd;
  logic                clear_n;
  logic                set_n;

  logic [TOTAL_W-1:0]  running_total;
  logic [TOTAL_W-1:0]  running_total_next;
  logic                aborted;
  logic                aborted_next;

  logic [PAY_W-1:0]    pay;
  logic [TOTAL_W-1:0]  base_total;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  sum_sat;

  logic [STAT_W-1:0]   res_status;
  logic [IDX_W-1:0]    res_index;
  logic [PAY_W-1:0]    res_pay;
  logic                res_done;

  logic                out_valid;
  logic [IDX_W-1:0]    out_index;
  logic [PAY_W-1:0]    out_pay;
  logic [STAT_W-1:0]   out_status;
  logic                out_done;

  assign s1_fire      = s1_valid && (!out_valid || result.ready);
  assign sector.ready = !s1_valid || s1_fire;
  assign accept       = sector.valid && sector.ready;

  fscf_locate u_locate (
    .track_number  (sector.track_number),
    .sector_number (sector.sector_number),
    .loc           (loc)
  );

  fscf_visit_map u_visit_map (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_index  (loc.index),
    .cur_index (s1_loc.index),
    .cmd       (cmd),
    .visited   (visited)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_start       <= sector.chain_start;
      s1_kind        <= sector.file_kind;
      s1_link_track  <= sector.link_track;
      s1_link_sector <= sector.link_sector;
      s1_loc         <= loc;
    end
  end

  // payload of this sector, final count capped at a full sector
  always_comb begin
    if (s1_link_track != '0) begin
      pay = DATA_PER_SECTOR;
    end else if (s1_link_sector <= 8'd1) begin
      pay = '0;
    end else if (s1_link_sector == 8'd255) begin
      pay = DATA_PER_SECTOR;
    end else begin
      pay = s1_link_sector - 8'd1;
    end
  end

  assign base_total = s1_start ? '0 : running_total;
  assign sum        = {1'b0, base_total} + (TOTAL_W + 1)'(pay);
  assign sum_sat    = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    res_status         = ST_OK;
    res_index          = '0;
    res_pay            = '0;
    res_done           = 1'b0;
    clear_n            = 1'b0;
    set_n              = 1'b0;
    running_total_next = running_total;
    aborted_next       = aborted;
    if (s1_start) begin
      clear_n            = 1'b1;
      running_total_next = '0;
      aborted_next       = 1'b0;
    end
    if (s1_start && (s1_kind != KIND_PROGRAM)) begin
      res_status   = ST_TYPE;
      res_done     = 1'b1;
      aborted_next = 1'b1;
    end else if (s1_start && s1_loc.trk_zero) begin
      res_status   = ST_MALFORMED;
      res_done     = 1'b1;
      aborted_next = 1'b1;
    end else if (!s1_start && aborted) begin
      res_status = ST_ABORTED;
    end else if (s1_loc.trk_err) begin
      res_status   = ST_TRACK;
      res_done     = 1'b1;
      aborted_next = 1'b1;
    end else if (s1_loc.sec_err) begin
      res_status   = ST_MALFORMED;
      res_done     = 1'b1;
      aborted_next = 1'b1;
    end else if (visited && !s1_start) begin
      res_status   = ST_LOOP;
      res_done     = 1'b1;
      aborted_next = 1'b1;
    end else begin
      set_n              = 1'b1;
      running_total_next = sum_sat;
      res_index          = s1_loc.index;
      res_pay            = pay;
      if (s1_link_track == '0) begin
        res_done     = 1'b1;
        aborted_next = 1'b1;
        res_status   = (sum_sat < TOTAL_W'(2)) ? ST_SHORT : ST_OK;
      end
    end
  end

  assign cmd.clear = clear_n && s1_fire;
  assign cmd.set   = set_n && s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
      aborted       <= 1'b0;
    end else if (s1_fire) begin
      running_total <= running_total_next;
      aborted       <= aborted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_index  <= res_index;
      out_pay    <= res_pay;
      out_status <= res_status;
      out_done   <= res_done;
    end
  end

  assign result.valid         = out_valid;
  assign result.byte_offset   = {out_index, 8'd0};
  assign result.linear_index  = out_index;
  assign result.payload_bytes = out_pay;
  assign result.status        = out_status;
  assign result.chain_done    = out_done;

  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && res_done) |=> aborted)
    else $error("chain end did not set the abort flag");

  assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status == ST_ABORTED)) |->
      (!result.chain_done && (result.linear_index == '0) && (result.payload_bytes == '0)))
    else $error("aborted result carries data");

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |-> !accept ##1 (s1_valid && $stable(s1_loc)))
    else $error("stalled item disturbed");

  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_start) |=> (running_total == $past(running_total_next)) &&
      (running_total <= TOTAL_W'(DATA_PER_SECTOR)))
    else $error("chain start total not restarted");

endmodule
